// ===== design/alle_pkg.sv =====
// types and constants shared by the linked list engine
// controller, datapath and checker; no dependencies
package alle_pkg;

    // most results emitted by one list out request
    localparam int MAX_RESULTS = 16;

    // request codes as they arrive on the op field
    typedef enum logic [2:0] {
        OP_ADD_FIRST = 3'd0,
        OP_ADD_AFTER = 3'd1,
        OP_ADD_LAST  = 3'd2,
        OP_DEL_FIRST = 3'd3,
        OP_DEL_AFTER = 3'd4,
        OP_DEL_LAST  = 3'd5,
        OP_DEL_ALL   = 3'd6,
        OP_LIST_OUT  = 3'd7
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    // micro operations issued by the controller to the datapath
    typedef enum logic [4:0] {
        UOP_NOP         = 5'd0,
        UOP_LOAD        = 5'd1,
        UOP_RD_HEAD     = 5'd2,
        UOP_RD_POS      = 5'd3,
        UOP_SCAN_STEP   = 5'd4,
        UOP_TAKE_FIRST  = 5'd5,
        UOP_TAKE_AFTER  = 5'd6,
        UOP_SET_POS     = 5'd7,
        UOP_WALK_STEP   = 5'd8,
        UOP_LINK_NEW    = 5'd9,
        UOP_LINK_POS    = 5'd10,
        UOP_DEL_FIRST   = 5'd11,
        UOP_DA_VICT     = 5'd12,
        UOP_DA_FIX      = 5'd13,
        UOP_DL_FIX      = 5'd14,
        UOP_CLR_ALL     = 5'd15,
        UOP_EMIT_STATUS = 5'd16,
        UOP_LIST_EMIT   = 5'd17
    } t_uop;

    // command from controller to datapath
    typedef struct packed {
        t_uop    uop;
        t_status status;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic empty;     // head is end of list
        logic full;      // every slot taken
        logic pos_ok;    // given slot is in range and occupied
        logic scan_hit;  // slot under the scan pointer is free
        logic lrd_end;   // link just read is end of list
        logic list_fin;  // current list out word is the final one
        logic out_free;  // output register can take a word
    } t_dp_stat;

endpackage

// ===== design/alle_ctrl.sv =====
// controller state machine of the linked list engine
// depends on alle_pkg; drives alle_dp through command and status structs
module alle_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_op,
    input  alle_pkg::t_dp_stat i_stat,
    output alle_pkg::t_dp_cmd  o_cmd
);
    import alle_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DISPATCH = 11'b000_0000_0010,
        S_SCAN     = 11'b000_0000_0100,
        S_WALK     = 11'b000_0000_1000,
        S_AA_LINK  = 11'b000_0001_0000,
        S_AA_POS   = 11'b000_0010_0000,
        S_DELF     = 11'b000_0100_0000,
        S_DA_CHK   = 11'b000_1000_0000,
        S_DA_FIX   = 11'b001_0000_0000,
        S_LIST     = 11'b010_0000_0000,
        S_EMIT     = 11'b100_0000_0000
    } t_state;

    t_state  r_state, n_state;
    t_op     r_op, n_op;
    t_status r_status, n_status;
    t_uop    uop;

    // request words are taken only while idle
    assign o_stall = (r_state != S_IDLE);

    // next state and micro operation
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_status = r_status;
        uop      = UOP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    uop      = UOP_LOAD;
                    n_op     = t_op'(i_op);
                    n_status = ST_OK;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (r_op)
                    OP_ADD_FIRST: begin
                        if (i_stat.full) begin
                            n_status = ST_FULL;
                            n_state  = S_EMIT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    OP_ADD_AFTER: begin
                        if (i_stat.full) begin
                            n_status = ST_FULL;
                            n_state  = S_EMIT;
                        end else if (!i_stat.pos_ok) begin
                            n_status = ST_BADPOS;
                            n_state  = S_EMIT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    OP_ADD_LAST: begin
                        // add last on an empty list is add first
                        if (i_stat.empty) begin
                            n_op    = OP_ADD_FIRST;
                            n_state = S_SCAN;
                        end else if (i_stat.full) begin
                            n_status = ST_FULL;
                            n_state  = S_EMIT;
                        end else begin
                            uop     = UOP_RD_HEAD;
                            n_state = S_WALK;
                        end
                    end
                    OP_DEL_FIRST: begin
                        if (i_stat.empty) begin
                            n_status = ST_EMPTY;
                            n_state  = S_EMIT;
                        end else begin
                            uop     = UOP_RD_HEAD;
                            n_state = S_DELF;
                        end
                    end
                    OP_DEL_AFTER: begin
                        if (!i_stat.pos_ok) begin
                            n_status = ST_BADPOS;
                            n_state  = S_EMIT;
                        end else begin
                            uop     = UOP_RD_POS;
                            n_state = S_DA_CHK;
                        end
                    end
                    OP_DEL_LAST: begin
                        if (i_stat.empty) begin
                            n_status = ST_EMPTY;
                            n_state  = S_EMIT;
                        end else begin
                            uop     = UOP_RD_HEAD;
                            n_state = S_WALK;
                        end
                    end
                    OP_DEL_ALL: begin
                        uop     = UOP_CLR_ALL;
                        n_state = S_EMIT;
                    end
                    OP_LIST_OUT: begin
                        if (i_stat.empty) begin
                            n_status = ST_EMPTY;
                            n_state  = S_EMIT;
                        end else begin
                            uop     = UOP_RD_HEAD;
                            n_state = S_LIST;
                        end
                    end
                    default: n_state = S_EMIT;
                endcase
            end
            S_SCAN: begin
                // one slot a cycle until the lowest free one is found
                if (i_stat.scan_hit) begin
                    if (r_op == OP_ADD_FIRST) begin
                        uop     = UOP_TAKE_FIRST;
                        n_state = S_EMIT;
                    end else begin
                        uop     = UOP_TAKE_AFTER;
                        n_state = S_AA_LINK;
                    end
                end else begin
                    uop = UOP_SCAN_STEP;
                end
            end
            S_WALK: begin
                // follow links one slot a cycle to the tail
                if (!i_stat.lrd_end) begin
                    uop = UOP_WALK_STEP;
                end else if (r_op == OP_DEL_LAST) begin
                    uop     = UOP_DL_FIX;
                    n_state = S_EMIT;
                end else begin
                    uop     = UOP_SET_POS;
                    n_state = S_SCAN;
                end
            end
            S_AA_LINK: begin
                uop     = UOP_LINK_NEW;
                n_state = S_AA_POS;
            end
            S_AA_POS: begin
                uop     = UOP_LINK_POS;
                n_state = S_EMIT;
            end
            S_DELF: begin
                uop     = UOP_DEL_FIRST;
                n_state = S_EMIT;
            end
            S_DA_CHK: begin
                if (i_stat.lrd_end) begin
                    n_status = ST_BADPOS;
                    n_state  = S_EMIT;
                end else begin
                    uop     = UOP_DA_VICT;
                    n_state = S_DA_FIX;
                end
            end
            S_DA_FIX: begin
                uop     = UOP_DA_FIX;
                n_state = S_EMIT;
            end
            S_LIST: begin
                // one entry word per cycle while the output can take it
                if (i_stat.out_free) begin
                    uop = UOP_LIST_EMIT;
                    if (i_stat.list_fin) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    uop     = UOP_EMIT_STATUS;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd.uop    = uop;
    assign o_cmd.status = r_status;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request code and pending status
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_status <= n_status;
    end

endmodule

// ===== design/alle_dp.sv =====
// datapath of the linked list engine: head, count, free map, link and
// payload memories, walk and scan pointers, output register; uses alle_pkg
module alle_dp #(
    parameter int SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  alle_pkg::t_dp_cmd  i_cmd,
    output alle_pkg::t_dp_stat o_stat,
    input  logic [3:0]         i_position,
    input  logic [31:0]        i_brand_code,
    input  logic [31:0]        i_colour_code,
    input  logic [15:0]        i_item_size,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic [3:0]         o_slot,
    output logic [4:0]         o_entry_count,
    output logic [31:0]        o_out_brand,
    output logic [31:0]        o_out_colour,
    output logic [15:0]        o_out_size,
    output logic               o_last
);
    import alle_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int NW = $clog2(MAX_RESULTS);
    localparam int PW = 80;
    localparam logic [LW-1:0] LINK_END = LW'(SLOTS);

    // link and payload memories
    logic [LW-1:0] mem_link [SLOTS];
    logic [PW-1:0] mem_pay  [SLOTS];

    // control state
    logic [LW-1:0]    r_head;
    logic [CW-1:0]    r_count;
    logic [SLOTS-1:0] r_free;
    logic             r_ovalid;

    // working registers
    logic [IW-1:0] r_pidx;
    logic          r_inrange;
    logic [31:0]   r_b;
    logic [31:0]   r_c;
    logic [15:0]   r_s;
    logic [IW-1:0] r_cur;
    logic [LW-1:0] r_pre;
    logic [IW-1:0] r_scan;
    logic [IW-1:0] r_k;
    logic [NW-1:0] r_n;
    logic [LW-1:0] r_lrd;
    logic [PW-1:0] r_prd;

    // output register
    t_status     r_ostatus;
    logic [3:0]  r_oslot;
    logic [4:0]  r_ocount;
    logic [31:0] r_obrand;
    logic [31:0] r_ocolour;
    logic [15:0] r_osize;
    logic        r_olast;

    // memory port controls
    logic          link_we;
    logic [IW-1:0] link_wa;
    logic [LW-1:0] link_wd;
    logic          pay_we;
    logic          rd_en;
    logic [IW-1:0] rd_a;

    logic lrd_end;
    logic list_fin;
    logic out_free;

    assign lrd_end  = (r_lrd == LINK_END);
    assign list_fin = lrd_end || (r_n == NW'(MAX_RESULTS - 1));
    assign out_free = !r_ovalid || !i_stall;

    // status back to the controller
    assign o_stat.empty    = (r_head == LINK_END);
    assign o_stat.full     = (r_count == CW'(SLOTS));
    assign o_stat.pos_ok   = r_inrange && !r_free[r_pidx];
    assign o_stat.scan_hit = r_free[r_scan];
    assign o_stat.lrd_end  = lrd_end;
    assign o_stat.list_fin = list_fin;
    assign o_stat.out_free = out_free;

    // memory port selection per micro operation
    always_comb begin
        link_we = 1'b0;
        link_wa = r_k;
        link_wd = r_lrd;
        pay_we  = 1'b0;
        rd_en   = 1'b0;
        rd_a    = IW'(r_lrd);
        unique case (i_cmd.uop)
            UOP_RD_HEAD: begin
                rd_en = 1'b1;
                rd_a  = IW'(r_head);
            end
            UOP_RD_POS: begin
                rd_en = 1'b1;
                rd_a  = r_pidx;
            end
            UOP_TAKE_FIRST: begin
                pay_we  = 1'b1;
                link_we = 1'b1;
                link_wa = r_scan;
                link_wd = r_head;
            end
            UOP_TAKE_AFTER: begin
                // fetch the predecessor's link alongside the payload write
                pay_we = 1'b1;
                rd_en  = 1'b1;
                rd_a   = r_pidx;
            end
            UOP_LINK_NEW: begin
                link_we = 1'b1;
                link_wa = r_k;
                link_wd = r_lrd;
            end
            UOP_LINK_POS: begin
                link_we = 1'b1;
                link_wa = r_pidx;
                link_wd = LW'(r_k);
            end
            UOP_DA_FIX: begin
                link_we = 1'b1;
                link_wa = r_pidx;
                link_wd = r_lrd;
            end
            UOP_DL_FIX: begin
                link_we = (r_pre != LINK_END);
                link_wa = IW'(r_pre);
                link_wd = LINK_END;
            end
            UOP_WALK_STEP, UOP_DA_VICT: begin
                rd_en = 1'b1;
            end
            UOP_LIST_EMIT: begin
                rd_en = !lrd_end;
            end
            default: begin
            end
        endcase
    end

    // memories with registered read
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            mem_link[link_wa] <= link_wd;
        end
        if (pay_we) begin
            mem_pay[r_scan] <= {r_b, r_c, r_s};
        end
        if (rd_en) begin
            r_lrd <= mem_link[rd_a];
            r_prd <= mem_pay[rd_a];
        end
    end

    // head, count, free map and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= LINK_END;
            r_count  <= '0;
            r_free   <= '1;
            r_ovalid <= 1'b0;
        end else begin
            unique case (i_cmd.uop)
                UOP_TAKE_FIRST: begin
                    r_head         <= LW'(r_scan);
                    r_free[r_scan] <= 1'b0;
                    r_count        <= r_count + CW'(1);
                end
                UOP_TAKE_AFTER: begin
                    r_free[r_scan] <= 1'b0;
                    r_count        <= r_count + CW'(1);
                end
                UOP_DEL_FIRST: begin
                    r_head        <= r_lrd;
                    r_free[r_cur] <= 1'b1;
                    r_count       <= r_count - CW'(1);
                end
                UOP_DA_FIX: begin
                    r_free[r_cur] <= 1'b1;
                    r_count       <= r_count - CW'(1);
                end
                UOP_DL_FIX: begin
                    if (r_pre == LINK_END) begin
                        r_head <= LINK_END;
                    end
                    r_free[r_cur] <= 1'b1;
                    r_count       <= r_count - CW'(1);
                end
                UOP_CLR_ALL: begin
                    r_head  <= LINK_END;
                    r_free  <= '1;
                    r_count <= '0;
                end
                default: begin
                end
            endcase
            if (i_cmd.uop == UOP_EMIT_STATUS || i_cmd.uop == UOP_LIST_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // working registers and output word
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.uop)
            UOP_LOAD: begin
                r_pidx    <= IW'(i_position);
                r_inrange <= (32'(i_position) < 32'(SLOTS));
                r_b       <= i_brand_code;
                r_c       <= i_colour_code;
                r_s       <= i_item_size;
                r_cur     <= IW'(r_head);
                r_pre     <= LINK_END;
                r_scan    <= '0;
                r_n       <= '0;
            end
            UOP_SCAN_STEP: begin
                r_scan <= r_scan + IW'(1);
            end
            UOP_TAKE_FIRST, UOP_TAKE_AFTER: begin
                r_k <= r_scan;
            end
            UOP_SET_POS: begin
                r_pidx <= r_cur;
            end
            UOP_WALK_STEP: begin
                r_pre <= LW'(r_cur);
                r_cur <= IW'(r_lrd);
            end
            UOP_DEL_FIRST, UOP_DL_FIX: begin
                r_k <= r_cur;
            end
            UOP_DA_VICT: begin
                r_cur <= IW'(r_lrd);
                r_k   <= IW'(r_lrd);
            end
            UOP_CLR_ALL: begin
                r_k <= '0;
            end
            UOP_EMIT_STATUS: begin
                r_ostatus <= i_cmd.status;
                r_oslot   <= (i_cmd.status == ST_OK) ? 4'(r_k) : 4'd0;
                r_ocount  <= 5'(r_count);
                r_obrand  <= '0;
                r_ocolour <= '0;
                r_osize   <= '0;
                r_olast   <= 1'b1;
            end
            UOP_LIST_EMIT: begin
                r_ostatus <= ST_OK;
                r_oslot   <= 4'(r_cur);
                r_ocount  <= 5'(r_count);
                r_obrand  <= r_prd[79:48];
                r_ocolour <= r_prd[47:16];
                r_osize   <= r_prd[15:0];
                r_olast   <= list_fin;
                r_cur     <= IW'(r_lrd);
                r_n       <= r_n + NW'(1);
            end
            default: begin
            end
        endcase
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_slot        = r_oslot;
    assign o_entry_count = r_ocount;
    assign o_out_brand   = r_obrand;
    assign o_out_colour  = r_ocolour;
    assign o_out_size    = r_osize;
    assign o_last        = r_olast;

endmodule

// ===== design/array_linked_list_engine.sv =====
// top level of the linked list engine: controller plus datapath
// depends on alle_pkg, alle_ctrl and alle_dp
//
// Usage:
//   Request channel (i_valid / o_stall) carries one word: op, position and
//   the payload of a new entry. Result channel (o_valid / i_stall) carries
//   status, slot, entry count, entry payload and last.
//   Each request gives exactly one status word, except list out, which gives
//   one word per entry in list order (at most 16), the final one with last.
//   One request is worked on at a time; o_stall is high from acceptance until
//   its final word is in the output register, while that word may still wait.
//   Steps: delete all and status words decided at dispatch go from dispatch
//   straight to emit; add first scans for the lowest free slot (one slot
//   scanned per cycle); add after also links the new slot in; add last
//   walks to the tail and then scans, and delete last walks to the tail,
//   both following one link per cycle through the link memory read port;
//   list out gives one entry word per cycle while the output can take it.
//   Reset empties the list (all slots free) and clears the output valid;
//   no clearing pass is needed. While the receiver stalls the output word
//   holds and the engine waits before writing its next word.
module array_linked_list_engine #(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic [3:0]  i_position,
    input  logic [31:0] i_brand_code,
    input  logic [31:0] i_colour_code,
    input  logic [15:0] i_item_size,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [3:0]  o_slot,
    output logic [4:0]  o_entry_count,
    output logic [31:0] o_out_brand,
    output logic [31:0] o_out_colour,
    output logic [15:0] o_out_size,
    output logic        o_last
);
    import alle_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencing of each request
    alle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // list storage and result word
    alle_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_position    (i_position),
        .i_brand_code  (i_brand_code),
        .i_colour_code (i_colour_code),
        .i_item_size   (i_item_size),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_entry_count (o_entry_count),
        .o_out_brand   (o_out_brand),
        .o_out_colour  (o_out_colour),
        .o_out_size    (o_out_size),
        .o_last        (o_last)
    );

endmodule

// ===== design/alle_chk.sv =====
// port-level checks of the linked list engine, bound to the top level
// depends on alle_pkg and array_linked_list_engine
module alle_chk #(
    parameter int SLOTS = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [3:0]  o_slot,
    input logic [4:0]  o_entry_count,
    input logic [31:0] o_out_brand,
    input logic        o_last
);
    import alle_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_slot) && $stable(o_last))
        else $error("output word changed under stall");

    // one request at a time: an accepted word closes the input
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input open right after acceptance");

    // error results are single, final and carry no entry
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_last && o_slot == 4'd0
            && o_out_brand == 32'd0)
        else $error("error word not final or carries data");

    // empty status only when no entries
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> o_entry_count == 5'd0)
        else $error("empty status with entries");

    // full status only when every slot is taken
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_entry_count == 5'(SLOTS))
        else $error("full status with free slots");

endmodule

bind array_linked_list_engine alle_chk #(.SLOTS(SLOTS)) u_alle_chk (.*);
